// ===== design/ttf_pkg.sv =====
// Package for the triangle tangent frame block.
// Holds the fixed-point constants and the sequencer state types.
// Used by ttf_norm and triangle_tangent_frame; depends on nothing.
package ttf_pkg;

    localparam int INNER_FRAC = 28;
    localparam int INNER_W    = 30;
    localparam int SCALE_BITS = 30;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = 32;
    localparam int ROOT_POS_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_TAN,
        ST_DOT,
        ST_REJ,
        ST_NORM,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PASS_NORMAL,
        PASS_TANGENT,
        PASS_REJECT,
        PASS_BITAN
    } pass_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SCALE,
        NS_SQUARE,
        NS_ROOT,
        NS_DIV_LOAD,
        NS_DIV,
        NS_DONE
    } nstate_t;

endpackage

// ===== design/ttf_if.sv =====
// Channel interfaces of the triangle tangent frame block.
// A vertex channel and a frame channel with valid/ready handshakes; no dependencies.
interface ttf_vertex_if #(
    parameter int POSITION_BITS = 32,
    parameter int TEXCOORD_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
    logic signed [TEXCOORD_BITS-1:0] tex_u;
    logic signed [TEXCOORD_BITS-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttf_frame_if #(
    parameter int OUTPUT_FRAC_BITS = 14
);
    logic                               valid;
    logic                               ready;
    logic signed [OUTPUT_FRAC_BITS+1:0] normal_x;
    logic signed [OUTPUT_FRAC_BITS+1:0] normal_y;
    logic signed [OUTPUT_FRAC_BITS+1:0] normal_z;
    logic signed [OUTPUT_FRAC_BITS+1:0] tangent_x;
    logic signed [OUTPUT_FRAC_BITS+1:0] tangent_y;
    logic signed [OUTPUT_FRAC_BITS+1:0] tangent_z;
    logic signed [OUTPUT_FRAC_BITS+1:0] bitangent_x;
    logic signed [OUTPUT_FRAC_BITS+1:0] bitangent_y;
    logic signed [OUTPUT_FRAC_BITS+1:0] bitangent_z;

    modport source (output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
                    tangent_z, bitangent_x, bitangent_y, bitangent_z, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, tangent_x, tangent_y,
                  tangent_z, bitangent_x, bitangent_y, bitangent_z, output ready);
endinterface

// ===== design/ttf_mul.sv =====
// Shared signed multiplier with a registered product.
// Used by the sequencer in triangle_tangent_frame; no package dependencies.
module ttf_mul #(
    parameter int MW = 33
) (
    input  logic                   clk,
    input  logic signed [MW-1:0]   a,
    input  logic signed [MW-1:0]   b,
    output logic signed [2*MW-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

// ===== design/ttf_norm.sv =====
// Vector normalization unit: power-of-two scaling, bitwise square root and
// a restoring divider that runs one quotient bit per cycle. Depends on ttf_pkg.
module ttf_norm #(
    parameter int VW       = 67,
    parameter int OUT_FRAC = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [VW-1:0]            vec [3],
    output logic                            done,
    output logic signed [ttf_pkg::INNER_W-1:0] inner [3],
    output logic signed [OUT_FRAC+1:0]      outv [3]
);

    localparam int OW   = OUT_FRAC + 2;
    localparam int FMAX = (OUT_FRAC > ttf_pkg::INNER_FRAC) ? OUT_FRAC : ttf_pkg::INNER_FRAC;
    localparam int QB   = FMAX + 2;
    localparam int NW   = FMAX + 32;
    localparam int CW   = $clog2(QB);
    localparam int SB   = ttf_pkg::SCALE_BITS;

    ttf_pkg::nstate_t state_reg, state_next;

    logic [VW-1:0]                        mag_reg [3];
    logic                                 neg_reg [3];
    logic [1:0]                           idx_reg;
    logic                                 prec_reg;
    logic [ttf_pkg::SUM_W-1:0]            sum_reg;
    logic [ttf_pkg::SUM_W-1:0]            root_reg;
    logic [ttf_pkg::ROOT_POS_W-1:0]       pos_reg;
    logic [ttf_pkg::LEN_W-1:0]            rem_reg;
    logic [QB-1:0]                        nlow_reg;
    logic [QB-1:0]                        quo_reg;
    logic [CW-1:0]                        cnt_reg;
    logic signed [ttf_pkg::INNER_W-1:0]   inner_reg [3];
    logic signed [OW-1:0]                 outv_reg [3];

    logic [VW-1:0]                 or_w;
    logic                          hi8, hi1, lo8, lo1;
    logic [SB-1:0]                 s_cur;
    logic [2*SB-1:0]               sq;
    logic [ttf_pkg::SUM_W-1:0]     root_bit;
    logic [ttf_pkg::SUM_W-1:0]     root_try;
    logic [ttf_pkg::LEN_W-1:0]     len;
    logic [NW-1:0]                 num;
    logic [ttf_pkg::LEN_W:0]       trial;
    logic                          ge;
    logic [QB-1:0]                 q_fin;
    logic [QB-1:0]                 q_sgn;

    assign or_w = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign hi8  = (or_w >> (SB + 8)) != '0;
    assign hi1  = (or_w >> SB) != '0;
    assign lo8  = (or_w >> (SB - 9)) == '0;
    assign lo1  = (or_w >> (SB - 1)) == '0;

    always_comb
    begin
        case (idx_reg)
            2'd0:    s_cur = mag_reg[0][SB-1:0];
            2'd1:    s_cur = mag_reg[1][SB-1:0];
            default: s_cur = mag_reg[2][SB-1:0];
        endcase
    end

    assign sq       = s_cur * s_cur;
    assign root_bit = ttf_pkg::SUM_W'(1) << {pos_reg, 1'b0};
    assign root_try = root_reg + root_bit;
    assign len      = root_reg[ttf_pkg::LEN_W-1:0];
    assign num      = (prec_reg ? (NW'(s_cur) << OUT_FRAC)
                                : (NW'(s_cur) << ttf_pkg::INNER_FRAC)) + NW'(len >> 1);
    assign trial    = {rem_reg, nlow_reg[QB-1]};
    assign ge       = trial >= {1'b0, len};
    assign q_fin    = {quo_reg[QB-2:0], ge};

    always_comb
    begin
        case (idx_reg)
            2'd0:    q_sgn = neg_reg[0] ? (~q_fin + QB'(1)) : q_fin;
            2'd1:    q_sgn = neg_reg[1] ? (~q_fin + QB'(1)) : q_fin;
            default: q_sgn = neg_reg[2] ? (~q_fin + QB'(1)) : q_fin;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttf_pkg::NS_IDLE:
            begin
                if (start)
                    state_next = ttf_pkg::NS_SCALE;
            end
            ttf_pkg::NS_SCALE:
            begin
                if (or_w == '0)
                    state_next = ttf_pkg::NS_DONE;
                else if (!hi1 && !lo1)
                    state_next = ttf_pkg::NS_SQUARE;
            end
            ttf_pkg::NS_SQUARE:
            begin
                if (idx_reg == 2'd2)
                    state_next = ttf_pkg::NS_ROOT;
            end
            ttf_pkg::NS_ROOT:
            begin
                if (pos_reg == '0)
                    state_next = ttf_pkg::NS_DIV_LOAD;
            end
            ttf_pkg::NS_DIV_LOAD:
            begin
                state_next = ttf_pkg::NS_DIV;
            end
            ttf_pkg::NS_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = (prec_reg && idx_reg == 2'd2) ? ttf_pkg::NS_DONE
                                                               : ttf_pkg::NS_DIV_LOAD;
            end
            ttf_pkg::NS_DONE:
            begin
                state_next = ttf_pkg::NS_IDLE;
            end
            default:
            begin
                state_next = ttf_pkg::NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ttf_pkg::NS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttf_pkg::NS_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= vec[i][VW-1];
                    mag_reg[i] <= vec[i][VW-1] ? (~vec[i] + VW'(1)) : vec[i];
                end
                idx_reg  <= 2'd0;
                prec_reg <= 1'b0;
                sum_reg  <= '0;
            end
            ttf_pkg::NS_SCALE:
            begin
                if (or_w == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        inner_reg[i] <= '0;
                        outv_reg[i]  <= '0;
                    end
                end
                for (int i = 0; i < 3; i++)
                begin
                    if (hi8)
                        mag_reg[i] <= mag_reg[i] >> 8;
                    else if (hi1)
                        mag_reg[i] <= mag_reg[i] >> 1;
                    else if (lo8)
                        mag_reg[i] <= mag_reg[i] << 8;
                    else if (lo1)
                        mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            ttf_pkg::NS_SQUARE:
            begin
                sum_reg  <= sum_reg + ttf_pkg::SUM_W'(sq);
                idx_reg  <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                root_reg <= '0;
                pos_reg  <= '1;
            end
            ttf_pkg::NS_ROOT:
            begin
                if (sum_reg >= root_try)
                begin
                    sum_reg  <= sum_reg - root_try;
                    root_reg <= (root_reg >> 1) + root_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                pos_reg <= pos_reg - ttf_pkg::ROOT_POS_W'(1);
            end
            ttf_pkg::NS_DIV_LOAD:
            begin
                rem_reg  <= ttf_pkg::LEN_W'(num >> QB);
                nlow_reg <= num[QB-1:0];
                quo_reg  <= '0;
                cnt_reg  <= CW'(QB - 1);
            end
            ttf_pkg::NS_DIV:
            begin
                rem_reg  <= ge ? ttf_pkg::LEN_W'(trial - {1'b0, len})
                               : trial[ttf_pkg::LEN_W-1:0];
                quo_reg  <= q_fin;
                nlow_reg <= nlow_reg << 1;
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (prec_reg)
                        outv_reg[idx_reg] <= q_sgn[OW-1:0];
                    else
                        inner_reg[idx_reg] <= q_sgn[ttf_pkg::INNER_W-1:0];
                    prec_reg <= ~prec_reg;
                    if (prec_reg)
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = (state_reg == ttf_pkg::NS_DONE);
    assign inner = inner_reg;
    assign outv  = outv_reg;

endmodule

// ===== design/triangle_tangent_frame.sv =====
// Top level of the triangle tangent frame block: vertex capture, sequencer
// and result register. Depends on ttf_pkg, ttf_if, ttf_mul and ttf_norm.
//
//   channel  | modport | beat carries
//   ---------+---------+---------------------------------------------------
//   vtx      | sink    | pos_x/y/z Q16.16, tex_u/v Q8.16, one corner
//   frame    | source  | normal, tangent, bitangent, each x/y/z in Q1.14
//
// The first two corners are only stored; the third starts the work: products on the shared
// multiplier and four normalizations, mostly six divisions each (none for a zero vector).
// Reset clears the corner count and the sequencer; held corners are not cleared.
// A finished frame waits in its register while the first two corners of the next
// triangle are taken; the third waits until the frame beat is accepted.
module triangle_tangent_frame #(
    parameter int POSITION_BITS    = 32,
    parameter int TEXCOORD_BITS    = 24,
    parameter int OUTPUT_FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    ttf_vertex_if.sink  vtx,
    ttf_frame_if.source frame
);

    localparam int PB  = POSITION_BITS;
    localparam int TB  = TEXCOORD_BITS;
    localparam int DW  = PB + 1;
    localparam int UW  = TB + 1;
    localparam int IW  = ttf_pkg::INNER_W;
    localparam int MW0 = (DW > UW) ? DW : UW;
    localparam int MW  = (MW0 > IW + 2) ? MW0 : IW + 2;
    localparam int PW  = 2 * MW;
    localparam int VW  = PW + 1;
    localparam int AW  = PW + 2;
    localparam int OW  = OUTPUT_FRAC_BITS + 2;

    ttf_pkg::state_t state_reg, state_next;
    ttf_pkg::pass_t  pass_reg;

    logic [1:0]            cnt_reg;
    logic [PB-1:0]         hp0_reg [3];
    logic [PB-1:0]         hp1_reg [3];
    logic [TB-1:0]         huv0_reg [2];
    logic [TB-1:0]         huv1_reg [2];
    logic signed [DW-1:0]  ab_reg [3];
    logic signed [DW-1:0]  ac_reg [3];
    logic signed [UW-1:0]  d1_reg [2];
    logic signed [UW-1:0]  d2_reg [2];
    logic [2:0]            k_reg;
    logic                  ph_reg;
    logic signed [AW-1:0]  acc_reg;
    logic signed [VW-1:0]  vec_reg [3];
    logic signed [IW-1:0]  ni_reg [3];
    logic signed [IW-1:0]  ti_reg [3];
    logic signed [MW-1:0]  d_reg;
    logic signed [OW-1:0]  no_reg [3];
    logic signed [OW-1:0]  to_reg [3];
    logic signed [OW-1:0]  bo_reg [3];
    logic                  start_reg;

    logic [PB-1:0]         cur_pos [3];
    logic [TB-1:0]         cur_uv [2];
    logic                  in_fire;
    logic                  out_fire;
    logic                  last_k;
    logic signed [MW-1:0]  xa [3];
    logic signed [MW-1:0]  xb [3];
    logic signed [MW-1:0]  mul_a, mul_b;
    logic signed [PW-1:0]  prod;
    logic signed [AW-1:0]  prod_ext;
    logic signed [AW-1:0]  acc_diff;
    logic signed [AW-1:0]  acc_sum;
    logic [1:0]            kc;
    logic                  norm_done;
    logic signed [IW-1:0]  norm_inner [3];
    logic signed [OW-1:0]  norm_outv [3];

    function automatic logic signed [AW-1:0] round_inner(input logic signed [AW-1:0] x);
        logic [AW-1:0] m;
        m = x[AW-1] ? (~x + AW'(1)) : x;
        m = (m + (AW'(1) << (ttf_pkg::INNER_FRAC - 1))) >> ttf_pkg::INNER_FRAC;
        return x[AW-1] ? -$signed(m) : $signed(m);
    endfunction

    assign cur_pos[0] = vtx.pos_x;
    assign cur_pos[1] = vtx.pos_y;
    assign cur_pos[2] = vtx.pos_z;
    assign cur_uv[0]  = vtx.tex_u;
    assign cur_uv[1]  = vtx.tex_v;

    assign vtx.ready   = (state_reg == ttf_pkg::ST_IDLE)
                      || (state_reg == ttf_pkg::ST_OUT && !cnt_reg[1]);
    assign frame.valid = (state_reg == ttf_pkg::ST_OUT);
    assign in_fire     = vtx.valid && vtx.ready;
    assign out_fire    = frame.valid && frame.ready;

    assign kc = (k_reg[1:0] == 2'd3) ? 2'd0 : k_reg[1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (pass_reg == ttf_pkg::PASS_NORMAL)
            begin
                xa[i] = MW'(ab_reg[i]);
                xb[i] = MW'(ac_reg[i]);
            end
            else
            begin
                xa[i] = MW'(ni_reg[i]);
                xb[i] = MW'(ti_reg[i]);
            end
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ttf_pkg::ST_CROSS:
            begin
                case (k_reg)
                    3'd0:    begin mul_a = xa[1]; mul_b = xb[2]; end
                    3'd1:    begin mul_a = xa[2]; mul_b = xb[1]; end
                    3'd2:    begin mul_a = xa[2]; mul_b = xb[0]; end
                    3'd3:    begin mul_a = xa[0]; mul_b = xb[2]; end
                    3'd4:    begin mul_a = xa[0]; mul_b = xb[1]; end
                    default: begin mul_a = xa[1]; mul_b = xb[0]; end
                endcase
            end
            ttf_pkg::ST_TAN:
            begin
                case (k_reg)
                    3'd0:    begin mul_a = MW'(ab_reg[0]); mul_b = MW'(d2_reg[1]); end
                    3'd1:    begin mul_a = MW'(ac_reg[0]); mul_b = MW'(d1_reg[1]); end
                    3'd2:    begin mul_a = MW'(ab_reg[1]); mul_b = MW'(d2_reg[1]); end
                    3'd3:    begin mul_a = MW'(ac_reg[1]); mul_b = MW'(d1_reg[1]); end
                    3'd4:    begin mul_a = MW'(ab_reg[2]); mul_b = MW'(d2_reg[1]); end
                    3'd5:    begin mul_a = MW'(ac_reg[2]); mul_b = MW'(d1_reg[1]); end
                    3'd6:    begin mul_a = MW'(d1_reg[0]); mul_b = MW'(d2_reg[1]); end
                    default: begin mul_a = MW'(d1_reg[1]); mul_b = MW'(d2_reg[0]); end
                endcase
            end
            ttf_pkg::ST_DOT:
            begin
                mul_a = MW'(ti_reg[kc]);
                mul_b = MW'(ni_reg[kc]);
            end
            ttf_pkg::ST_REJ:
            begin
                mul_a = MW'(ni_reg[kc]);
                mul_b = d_reg;
            end
            default:
            begin
            end
        endcase
    end

    ttf_mul #(.MW(MW)) u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    ttf_norm #(.VW(VW), .OUT_FRAC(OUTPUT_FRAC_BITS)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .vec   (vec_reg),
        .done  (norm_done),
        .inner (norm_inner),
        .outv  (norm_outv)
    );

    assign prod_ext = AW'(prod);
    assign acc_diff = acc_reg - prod_ext;
    assign acc_sum  = acc_reg + prod_ext;

    always_comb
    begin
        case (state_reg)
            ttf_pkg::ST_CROSS: last_k = (k_reg == 3'd5);
            ttf_pkg::ST_TAN:   last_k = (k_reg == 3'd7);
            default:           last_k = (k_reg == 3'd2);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttf_pkg::ST_IDLE:
            begin
                if (in_fire && cnt_reg[1])
                    state_next = ttf_pkg::ST_CROSS;
            end
            ttf_pkg::ST_CROSS, ttf_pkg::ST_TAN, ttf_pkg::ST_REJ:
            begin
                if (ph_reg && last_k)
                    state_next = ttf_pkg::ST_NORM;
            end
            ttf_pkg::ST_DOT:
            begin
                if (ph_reg && last_k)
                    state_next = ttf_pkg::ST_REJ;
            end
            ttf_pkg::ST_NORM:
            begin
                if (norm_done)
                begin
                    case (pass_reg)
                        ttf_pkg::PASS_NORMAL:  state_next = ttf_pkg::ST_TAN;
                        ttf_pkg::PASS_TANGENT: state_next = ttf_pkg::ST_DOT;
                        ttf_pkg::PASS_REJECT:  state_next = ttf_pkg::ST_CROSS;
                        default:               state_next = ttf_pkg::ST_OUT;
                    endcase
                end
            end
            ttf_pkg::ST_OUT:
            begin
                if (out_fire)
                    state_next = ttf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ttf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttf_pkg::ST_IDLE;
            pass_reg  <= ttf_pkg::PASS_NORMAL;
            cnt_reg   <= 2'd0;
            k_reg     <= 3'd0;
            ph_reg    <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_next == ttf_pkg::ST_NORM) && (state_reg != ttf_pkg::ST_NORM);
            if (in_fire)
                cnt_reg <= cnt_reg[1] ? 2'd0 : cnt_reg + 2'd1;
            if (state_reg == ttf_pkg::ST_CROSS || state_reg == ttf_pkg::ST_TAN
                || state_reg == ttf_pkg::ST_DOT || state_reg == ttf_pkg::ST_REJ)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg)
                    k_reg <= last_k ? 3'd0 : k_reg + 3'd1;
            end
            if (state_reg == ttf_pkg::ST_IDLE && in_fire && cnt_reg[1])
                pass_reg <= ttf_pkg::PASS_NORMAL;
            if (state_reg == ttf_pkg::ST_NORM && norm_done)
            begin
                case (pass_reg)
                    ttf_pkg::PASS_NORMAL:  pass_reg <= ttf_pkg::PASS_TANGENT;
                    ttf_pkg::PASS_TANGENT: pass_reg <= ttf_pkg::PASS_REJECT;
                    ttf_pkg::PASS_REJECT:  pass_reg <= ttf_pkg::PASS_BITAN;
                    default:               pass_reg <= ttf_pkg::PASS_BITAN;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!cnt_reg[1])
            begin
                if (cnt_reg[0])
                begin
                    hp1_reg  <= cur_pos;
                    huv1_reg <= cur_uv;
                end
                else
                begin
                    hp0_reg  <= cur_pos;
                    huv0_reg <= cur_uv;
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ab_reg[i] <= $signed(DW'($signed(hp1_reg[i])))
                               - $signed(DW'($signed(hp0_reg[i])));
                    ac_reg[i] <= $signed(DW'($signed(cur_pos[i])))
                               - $signed(DW'($signed(hp0_reg[i])));
                end
                for (int i = 0; i < 2; i++)
                begin
                    d1_reg[i] <= $signed(UW'($signed(huv0_reg[i])))
                               - $signed(UW'($signed(huv1_reg[i])));
                    d2_reg[i] <= $signed(UW'($signed(huv0_reg[i])))
                               - $signed(UW'($signed(cur_uv[i])));
                end
            end
        end

        if (ph_reg)
        begin
            case (state_reg)
                ttf_pkg::ST_CROSS, ttf_pkg::ST_TAN:
                begin
                    if (!k_reg[0])
                        acc_reg <= prod_ext;
                    else if (k_reg == 3'd7)
                    begin
                        if (acc_diff < 0)
                        begin
                            for (int i = 0; i < 3; i++)
                                vec_reg[i] <= -vec_reg[i];
                        end
                    end
                    else
                        vec_reg[k_reg[2:1]] <= VW'(acc_diff);
                end
                ttf_pkg::ST_DOT:
                begin
                    acc_reg <= (k_reg == 3'd0) ? prod_ext : acc_sum;
                    if (k_reg == 3'd2)
                        d_reg <= MW'(round_inner(acc_sum));
                end
                ttf_pkg::ST_REJ:
                begin
                    vec_reg[kc] <= VW'(AW'(ti_reg[kc]) - round_inner(prod_ext));
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == ttf_pkg::ST_NORM && norm_done)
        begin
            case (pass_reg)
                ttf_pkg::PASS_NORMAL:
                begin
                    ni_reg <= norm_inner;
                    no_reg <= norm_outv;
                end
                ttf_pkg::PASS_TANGENT:
                begin
                    ti_reg <= norm_inner;
                end
                ttf_pkg::PASS_REJECT:
                begin
                    ti_reg <= norm_inner;
                    to_reg <= norm_outv;
                end
                default:
                begin
                    bo_reg <= norm_outv;
                end
            endcase
        end
    end

    assign frame.normal_x    = no_reg[0];
    assign frame.normal_y    = no_reg[1];
    assign frame.normal_z    = no_reg[2];
    assign frame.tangent_x   = to_reg[0];
    assign frame.tangent_y   = to_reg[1];
    assign frame.tangent_z   = to_reg[2];
    assign frame.bitangent_x = bo_reg[0];
    assign frame.bitangent_y = bo_reg[1];
    assign frame.bitangent_z = bo_reg[2];

endmodule

// ===== design/ttf_checker.sv =====
// Port-level checker for triangle_tangent_frame and the bind that attaches it.
// Sees only the top-level handshakes and result fields; no package dependencies.
module ttf_checker #(
    parameter int OW = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [OW-1:0] normal_x,
    input logic signed [OW-1:0] tangent_x
);

    logic [1:0] cnt_reg;
    logic       pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
            if (in_valid && in_ready && cnt_reg == 2'd2)
                pend_reg <= 1'b1;
            else if (out_valid && out_ready)
                pend_reg <= 1'b0;
        end
    end

    // A frame appears only after a third corner has been taken.
    a_frame_follows_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> pend_reg)
        else $error("frame beat without a completed triangle");

    // No third corner is taken while the previous frame is still owed.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && in_valid && in_ready) |-> (cnt_reg != 2'd2))
        else $error("third corner taken while a frame is pending");

    // The x components of the normal and tangent never exceed one in magnitude.
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x <= (OW'(1) <<< (OW - 2)) && normal_x >= -(OW'(1) <<< (OW - 2))
                    && tangent_x <= (OW'(1) <<< (OW - 2))
                    && tangent_x >= -(OW'(1) <<< (OW - 2))))
        else $error("result component out of unit range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("frame beat withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(normal_x) && $stable(tangent_x)))
        else $error("frame beat changed while stalled");

endmodule

bind triangle_tangent_frame ttf_checker #(.OW(OUTPUT_FRAC_BITS + 2)) u_ttf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vtx.valid),
    .in_ready  (vtx.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .normal_x  (frame.normal_x),
    .tangent_x (frame.tangent_x)
);
